// File: src/link_flap_and_outage_monitor_unit_macros.svh
// Assertion macros for the link flap and outage monitor.
// Used by link_flap_and_outage_monitor_unit; expects aclk and aresetn in scope.
`ifndef LINK_FLAP_AND_OUTAGE_MONITOR_UNIT_MACROS_SVH
`define LINK_FLAP_AND_OUTAGE_MONITOR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LFOM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LFOM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/lfom_pkg.sv
// Shared types and constants for the link flap and outage monitor.
// No dependencies; used by link_flap_and_outage_monitor_unit.
package lfom_pkg;

    localparam int unsigned ADDR_W          = 32;
    localparam int unsigned TIME_BITS       = 48;
    localparam int unsigned SLOT_W          = 4;
    localparam int unsigned WIN_MIN_W       = 11;
    localparam int unsigned LIMIT_W         = 8;
    localparam int unsigned COUNT_W         = 9;
    localparam int unsigned MS_W            = 27;
    localparam int unsigned CFG_DATA_W      = 11;
    localparam int unsigned CFG_IDX_W       = 2;
    localparam int unsigned TABLE_DEPTH_DEF = 16;

    localparam int unsigned MS_PER_MINUTE   = 60000;
    localparam int unsigned DEF_WINDOW_MIN  = 10;
    localparam int unsigned DEF_LIMIT       = 5;
    localparam int unsigned DEF_OUTAGE_MIN  = 5;
    localparam int unsigned RST_WINDOW_MIN  = 10;
    localparam int unsigned RST_MAX_CHANGES = 5;
    localparam int unsigned RST_OUTAGE_MIN  = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_MINUTES = 2'd0,
        CFG_MAX_CHANGES    = 2'd1,
        CFG_OUTAGE_MINUTES = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_APPEND,
        ST_READ,
        ST_LOAD,
        ST_WIN_SUB,
        ST_WIN_CMP,
        ST_FLAP,
        ST_OUT_CMP,
        ST_WRITE,
        ST_RESULT
    } lfom_state_t;

    typedef struct packed {
        logic [ADDR_W-1:0]    device_address;
        logic                 is_disconnected;
        logic [TIME_BITS-1:0] now_ms;
    } lfom_in_t;

    typedef struct packed {
        logic [SLOT_W-1:0] entry_slot;
        logic              new_entry;
        logic              dropped;
        logic              flap_alarm;
        logic              outage_alarm;
    } lfom_out_t;

endpackage

// File: src/link_flap_and_outage_monitor_unit.sv
// Link flap and outage monitor: per-device status change and outage tracking.
// Depends on lfom_pkg and link_flap_and_outage_monitor_unit_macros.svh.
//
//   Channel   Ports                          Moves
//   --------  -----------------------------  -------------------------------------
//   report    s_valid, s_ready, s_data       one status request from a device
//   result    m_valid, m_ready, m_data       slot, new-entry, drop and alarm flags
//   config    cfg_wr_en, cfg_index, cfg_wdata  register writes, no read-back
//
// One request is handled at a time. A request with a zero address is answered
// in the cycle after acceptance. Otherwise the table is searched one slot per
// cycle; a new device that finds the table full is then answered as dropped,
// else seven further steps follow, the arithmetic ones sharing a single
// subtract-and-borrow unit. Reset is synchronous and active low; it clears the
// fill count and the sequencer and loads the configuration registers with their
// reset values. Per-slot state needs no clearing because a slot is initialised
// when it is appended. A stalled result holds the block.
`include "link_flap_and_outage_monitor_unit_macros.svh"

module link_flap_and_outage_monitor_unit #(
    parameter int unsigned TABLE_DEPTH = lfom_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  lfom_pkg::lfom_in_t              s_data,

    output logic                            m_valid,
    input  logic                            m_ready,
    output lfom_pkg::lfom_out_t             m_data,

    input  logic                            cfg_wr_en,
    input  logic [lfom_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lfom_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int unsigned IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned USED_W     = IDX_W + 1;
    localparam int unsigned TIME_W     = lfom_pkg::TIME_BITS;
    localparam int unsigned ADDR_W     = lfom_pkg::ADDR_W;
    localparam int unsigned COUNT_W    = lfom_pkg::COUNT_W;
    localparam int unsigned LIMIT_W    = lfom_pkg::LIMIT_W;
    localparam int unsigned WIN_MIN_W  = lfom_pkg::WIN_MIN_W;
    localparam int unsigned MS_W       = lfom_pkg::MS_W;
    localparam int unsigned SLOT_W     = lfom_pkg::SLOT_W;
    localparam int unsigned SLOT_EXT_W = IDX_W + SLOT_W;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [WIN_MIN_W-1:0] window_minutes_reg;
    logic [LIMIT_W-1:0]   max_changes_reg;
    logic [WIN_MIN_W-1:0] outage_minutes_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_minutes_reg <= WIN_MIN_W'(lfom_pkg::RST_WINDOW_MIN);
            max_changes_reg    <= LIMIT_W'(lfom_pkg::RST_MAX_CHANGES);
            outage_minutes_reg <= WIN_MIN_W'(lfom_pkg::RST_OUTAGE_MIN);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                lfom_pkg::CFG_WINDOW_MINUTES: begin
                    window_minutes_reg <= cfg_wdata[WIN_MIN_W-1:0];
                end
                lfom_pkg::CFG_MAX_CHANGES: begin
                    max_changes_reg <= cfg_wdata[LIMIT_W-1:0];
                end
                lfom_pkg::CFG_OUTAGE_MINUTES: begin
                    outage_minutes_reg <= cfg_wdata[WIN_MIN_W-1:0];
                end
                default: begin
                    // Unknown register indexes are ignored.
                end
            endcase
        end
    end

    // Effective settings: a zero window or zero limit falls back to both
    // defaults together, and a zero outage timeout falls back to its default.
    logic                 win_defaults;
    logic [WIN_MIN_W-1:0] win_min_eff;
    logic [LIMIT_W-1:0]   limit_eff;
    logic [WIN_MIN_W-1:0] outage_min_eff;

    assign win_defaults   = (window_minutes_reg == '0) || (max_changes_reg == '0);
    assign win_min_eff    = win_defaults ? WIN_MIN_W'(lfom_pkg::DEF_WINDOW_MIN)
                                         : window_minutes_reg;
    assign limit_eff      = win_defaults ? LIMIT_W'(lfom_pkg::DEF_LIMIT) : max_changes_reg;
    assign outage_min_eff = (outage_minutes_reg == '0) ?
                            WIN_MIN_W'(lfom_pkg::DEF_OUTAGE_MIN) : outage_minutes_reg;

    // ------------------------------------------------------------------
    // Sequencer and working registers.
    // ------------------------------------------------------------------
    lfom_pkg::lfom_state_t state_reg, state_next;
    logic [USED_W-1:0]     used_reg, used_next;

    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic                  disc_reg, disc_next;
    logic [TIME_W-1:0]     now_reg, now_next;
    logic [USED_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                  pend_reg, pend_next;
    logic [IDX_W-1:0]      pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0]      slot_reg, slot_next;
    logic                  fresh_reg, fresh_next;
    logic [MS_W-1:0]       win_ms_reg, win_ms_next;
    logic [LIMIT_W-1:0]    lim_reg, lim_next;
    logic [MS_W-1:0]       tmo_ms_reg, tmo_ms_next;
    logic [COUNT_W-1:0]    cnt_reg, cnt_next;
    logic [TIME_W-1:0]     ws_reg, ws_next;
    logic                  last_disc_reg, last_disc_next;
    logic [TIME_W-1:0]     os_reg, os_next;
    logic                  timing_reg, timing_next;
    logic [TIME_W-1:0]     elapsed_reg, elapsed_next;
    logic                  flap_reg, flap_next;
    logic                  outage_reg, outage_next;
    lfom_pkg::lfom_out_t   res_reg, res_next;

    // ------------------------------------------------------------------
    // Memories: the address table and the per-slot tracking state. Every
    // slot below the fill count has been written, so nothing else is read.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0]  tab_mem       [TABLE_DEPTH];
    logic [COUNT_W-1:0] cnt_mem       [TABLE_DEPTH];
    logic [TIME_W-1:0]  ws_mem        [TABLE_DEPTH];
    logic               last_disc_mem [TABLE_DEPTH];
    logic [TIME_W-1:0]  os_mem        [TABLE_DEPTH];
    logic               timing_mem    [TABLE_DEPTH];

    logic [ADDR_W-1:0]  tab_rd_reg;
    logic [COUNT_W-1:0] cnt_rd_reg;
    logic [TIME_W-1:0]  ws_rd_reg;
    logic               last_disc_rd_reg;
    logic [TIME_W-1:0]  os_rd_reg;
    logic               timing_rd_reg;

    logic tab_rd_en;
    logic tab_wr_en;
    logic ent_rd_en;
    logic ent_wr_en;

    always_ff @(posedge aclk) begin
        if (tab_wr_en) begin
            tab_mem[slot_reg] <= addr_reg;
        end
        if (tab_rd_en) begin
            tab_rd_reg <= tab_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (ent_wr_en) begin
            cnt_mem[slot_reg]       <= cnt_reg;
            ws_mem[slot_reg]        <= ws_reg;
            last_disc_mem[slot_reg] <= last_disc_reg;
            os_mem[slot_reg]        <= os_reg;
            timing_mem[slot_reg]    <= timing_reg;
        end
        if (ent_rd_en) begin
            cnt_rd_reg       <= cnt_mem[slot_reg];
            ws_rd_reg        <= ws_mem[slot_reg];
            last_disc_rd_reg <= last_disc_mem[slot_reg];
            os_rd_reg        <= os_mem[slot_reg];
            timing_rd_reg    <= timing_mem[slot_reg];
        end
    end

    // ------------------------------------------------------------------
    // Shared arithmetic unit: a modular subtract whose borrow also serves
    // as the "greater than" compare (b > a exactly when a - b borrows).
    // ------------------------------------------------------------------
    logic [TIME_W-1:0] alu_a;
    logic [TIME_W-1:0] alu_b;
    logic [TIME_W:0]   alu_res;
    logic [TIME_W-1:0] alu_diff;
    logic              alu_borrow;

    assign alu_res    = {1'b0, alu_a} - {1'b0, alu_b};
    assign alu_diff   = alu_res[TIME_W-1:0];
    assign alu_borrow = alu_res[TIME_W];

    // Search helpers.
    logic search_hit;
    logic search_more;
    logic table_full;
    logic flap_hit;
    logic s_accept;

    assign search_hit  = pend_reg && (tab_rd_reg == addr_reg);
    assign search_more = rd_idx_reg < used_reg;
    assign table_full  = used_reg == USED_W'(TABLE_DEPTH);
    assign flap_hit    = cnt_reg > COUNT_W'(lim_reg);
    assign s_accept    = s_valid && s_ready;

    // The reported slot is the low bits of the slot index.
    function automatic logic [SLOT_W-1:0] slot_ext_w(input logic [IDX_W-1:0] idx);
        logic [SLOT_EXT_W-1:0] wide;
        wide = SLOT_EXT_W'(idx);
        return wide[SLOT_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Next state.
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lfom_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.device_address == '0) begin
                        state_next = lfom_pkg::ST_RESULT;
                    end else begin
                        state_next = lfom_pkg::ST_SEARCH;
                    end
                end
            end
            lfom_pkg::ST_SEARCH: begin
                priority if (search_hit) begin
                    state_next = lfom_pkg::ST_READ;
                end else if (search_more) begin
                    state_next = lfom_pkg::ST_SEARCH;
                end else if (table_full) begin
                    state_next = lfom_pkg::ST_RESULT;
                end else begin
                    state_next = lfom_pkg::ST_APPEND;
                end
            end
            lfom_pkg::ST_APPEND:  state_next = lfom_pkg::ST_LOAD;
            lfom_pkg::ST_READ:    state_next = lfom_pkg::ST_LOAD;
            lfom_pkg::ST_LOAD:    state_next = lfom_pkg::ST_WIN_SUB;
            lfom_pkg::ST_WIN_SUB: state_next = lfom_pkg::ST_WIN_CMP;
            lfom_pkg::ST_WIN_CMP: state_next = lfom_pkg::ST_FLAP;
            lfom_pkg::ST_FLAP:    state_next = lfom_pkg::ST_OUT_CMP;
            lfom_pkg::ST_OUT_CMP: state_next = lfom_pkg::ST_WRITE;
            lfom_pkg::ST_WRITE:   state_next = lfom_pkg::ST_RESULT;
            lfom_pkg::ST_RESULT: begin
                if (m_ready) begin
                    state_next = lfom_pkg::ST_IDLE;
                end
            end
            default: state_next = lfom_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs and datapath.
    // ------------------------------------------------------------------
    always_comb begin
        s_ready        = 1'b0;
        m_valid        = 1'b0;
        tab_rd_en      = 1'b0;
        tab_wr_en      = 1'b0;
        ent_rd_en      = 1'b0;
        ent_wr_en      = 1'b0;
        alu_a          = now_reg;
        alu_b          = ws_reg;

        used_next      = used_reg;
        addr_next      = addr_reg;
        disc_next      = disc_reg;
        now_next       = now_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        slot_next      = slot_reg;
        fresh_next     = fresh_reg;
        win_ms_next    = win_ms_reg;
        lim_next       = lim_reg;
        tmo_ms_next    = tmo_ms_reg;
        cnt_next       = cnt_reg;
        ws_next        = ws_reg;
        last_disc_next = last_disc_reg;
        os_next        = os_reg;
        timing_next    = timing_reg;
        elapsed_next   = elapsed_reg;
        flap_next      = flap_reg;
        outage_next    = outage_reg;
        res_next       = res_reg;

        unique case (state_reg)
            lfom_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_accept) begin
                    addr_next   = s_data.device_address;
                    disc_next   = s_data.is_disconnected;
                    now_next    = s_data.now_ms;
                    rd_idx_next = '0;
                    pend_next   = 1'b0;
                    fresh_next  = 1'b0;
                    win_ms_next = MS_W'(win_min_eff) * MS_W'(lfom_pkg::MS_PER_MINUTE);
                    lim_next    = limit_eff;
                    res_next              = '0;
                    res_next.dropped      = s_data.device_address == '0;
                end
            end
            lfom_pkg::ST_SEARCH: begin
                priority if (search_hit) begin
                    slot_next = pend_idx_reg;
                end else if (search_more) begin
                    tab_rd_en     = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next   = rd_idx_reg + 1'b1;
                end else if (table_full) begin
                    res_next         = '0;
                    res_next.dropped = 1'b1;
                end else begin
                    slot_next = used_reg[IDX_W-1:0];
                end
            end
            lfom_pkg::ST_APPEND: begin
                tab_wr_en  = 1'b1;
                used_next  = used_reg + 1'b1;
                fresh_next = 1'b1;
            end
            lfom_pkg::ST_READ: begin
                ent_rd_en = 1'b1;
            end
            lfom_pkg::ST_LOAD: begin
                // A fresh slot starts its window now, with no count and no outage
                // timing, and is taken to have been disconnected.
                if (fresh_reg) begin
                    cnt_next       = '0;
                    last_disc_next = 1'b1;
                    timing_next    = 1'b0;
                    ws_next        = now_reg;
                end else begin
                    cnt_next       = cnt_rd_reg;
                    last_disc_next = last_disc_rd_reg;
                    timing_next    = timing_rd_reg;
                    ws_next        = ws_rd_reg;
                end
                os_next     = os_rd_reg;
                flap_next   = 1'b0;
                outage_next = 1'b0;
                tmo_ms_next = MS_W'(outage_min_eff) * MS_W'(lfom_pkg::MS_PER_MINUTE);
            end
            lfom_pkg::ST_WIN_SUB: begin
                alu_a        = now_reg;
                alu_b        = ws_reg;
                elapsed_next = alu_diff;
            end
            lfom_pkg::ST_WIN_CMP: begin
                // Borrow set means elapsed exceeds the window.
                alu_a = TIME_W'(win_ms_reg);
                alu_b = elapsed_reg;
                if (last_disc_reg != disc_reg) begin
                    if (!alu_borrow) begin
                        cnt_next = cnt_reg + 1'b1;
                    end else begin
                        cnt_next = '0;
                        ws_next  = now_reg;
                    end
                    last_disc_next = disc_reg;
                end else if (alu_borrow) begin
                    cnt_next = '0;
                    ws_next  = now_reg;
                end
            end
            lfom_pkg::ST_FLAP: begin
                if (flap_hit) begin
                    flap_next = 1'b1;
                    cnt_next  = '0;
                end
                alu_a        = now_reg;
                alu_b        = os_reg;
                elapsed_next = alu_diff;
            end
            lfom_pkg::ST_OUT_CMP: begin
                alu_a = TIME_W'(tmo_ms_reg);
                alu_b = elapsed_reg;
                if (disc_reg) begin
                    if (!timing_reg) begin
                        os_next     = now_reg;
                        timing_next = 1'b1;
                    end else if (alu_borrow) begin
                        timing_next = 1'b0;
                        outage_next = 1'b1;
                    end
                end else begin
                    os_next     = now_reg;
                    timing_next = 1'b1;
                end
            end
            lfom_pkg::ST_WRITE: begin
                ent_wr_en             = 1'b1;
                res_next.entry_slot   = slot_ext_w(slot_reg);
                res_next.new_entry    = fresh_reg;
                res_next.dropped      = 1'b0;
                res_next.flap_alarm   = flap_reg;
                res_next.outage_alarm = outage_reg;
            end
            lfom_pkg::ST_RESULT: begin
                m_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign m_data = res_reg;

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lfom_pkg::ST_IDLE;
            used_reg  <= '0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg      <= addr_next;
        disc_reg      <= disc_next;
        now_reg       <= now_next;
        rd_idx_reg    <= rd_idx_next;
        pend_reg      <= pend_next;
        pend_idx_reg  <= pend_idx_next;
        slot_reg      <= slot_next;
        fresh_reg     <= fresh_next;
        win_ms_reg    <= win_ms_next;
        lim_reg       <= lim_next;
        tmo_ms_reg    <= tmo_ms_next;
        cnt_reg       <= cnt_next;
        ws_reg        <= ws_next;
        last_disc_reg <= last_disc_next;
        os_reg        <= os_next;
        timing_reg    <= timing_next;
        elapsed_reg   <= elapsed_next;
        flap_reg      <= flap_next;
        outage_reg    <= outage_next;
        res_reg       <= res_next;
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `LFOM_ASSERT_SAME(a_used_bound, 1'b1, used_reg <= USED_W'(TABLE_DEPTH),
        "fill count beyond table depth")
    `LFOM_ASSERT_SAME(a_drop_clean, m_valid && m_data.dropped,
        !m_data.new_entry && !m_data.flap_alarm && !m_data.outage_alarm,
        "dropped result carries flags")
    `LFOM_ASSERT_NEXT(a_append_grows, state_reg == lfom_pkg::ST_APPEND,
        used_reg == $past(used_reg) + 1'b1, "append did not grow the table")
    `LFOM_ASSERT_NEXT(a_flap_clears, state_reg == lfom_pkg::ST_FLAP && flap_hit,
        cnt_reg == '0 && flap_reg, "flap alarm did not clear the count")

endmodule

// File: tb/tb_link_flap_and_outage_monitor_unit.sv
// Self-checking testbench for link_flap_and_outage_monitor_unit.
// Needs lfom_pkg and the unit itself; drives reports, checks results against
// an in-bench predictor of the per-device flap and outage tracking.
module tb_link_flap_and_outage_monitor_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // The longest answer time is a full table search plus the update steps.
    localparam int unsigned RESULT_LATENCY = lfom_pkg::TABLE_DEPTH_DEF + 10;
    // Cycles with no handshake and no register write before the run is abandoned.
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    // Register index that the block does not decode.
    localparam logic [lfom_pkg::CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam int unsigned PHASE_COUNT = 6;
    localparam int unsigned ITEMS_PER_PHASE = 267;
    localparam int unsigned DEPTH = lfom_pkg::TABLE_DEPTH_DEF;
    localparam int unsigned TB_W = lfom_pkg::TIME_BITS;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                s_valid = 1'b0;
    logic                s_ready;
    lfom_pkg::lfom_in_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    lfom_pkg::lfom_out_t m_data;

    logic                            cfg_wr_en = 1'b0;
    logic [lfom_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [lfom_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // Idle percentages of the two sides, changed between phases.
    int unsigned send_idle_pct = 31;
    int unsigned recv_idle_pct = 87;

    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;

    // Results that the predictor has worked out and the block still owes us.
    lfom_pkg::lfom_out_t pending_results[$];

    // Predictor copy of the configuration, starting at the reset values.
    logic [lfom_pkg::WIN_MIN_W-1:0] cur_window =
        lfom_pkg::WIN_MIN_W'(lfom_pkg::RST_WINDOW_MIN);
    logic [lfom_pkg::LIMIT_W-1:0]   cur_limit  =
        lfom_pkg::LIMIT_W'(lfom_pkg::RST_MAX_CHANGES);
    logic [lfom_pkg::WIN_MIN_W-1:0] cur_outage =
        lfom_pkg::WIN_MIN_W'(lfom_pkg::RST_OUTAGE_MIN);

    // Predictor copy of the device table and the per-slot tracking state.
    logic [lfom_pkg::ADDR_W-1:0]  dev_table   [DEPTH];
    int unsigned                  dev_count;
    logic [lfom_pkg::COUNT_W-1:0] chg_cnt     [DEPTH];
    logic [TB_W-1:0]              win_start   [DEPTH];
    bit                           win_on      [DEPTH];
    bit                           was_down    [DEPTH];
    logic [TB_W-1:0]              down_start  [DEPTH];
    bit                           down_timing [DEPTH];

    // Stimulus bookkeeping: the running timestamp and the set of devices that
    // the random traffic keeps reporting for.
    logic [TB_W-1:0]             clock_ms;
    logic [lfom_pkg::ADDR_W-1:0] pool_addr [DEPTH];
    bit                          pool_disc [DEPTH];

    link_flap_and_outage_monitor_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 12 ns clock period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // The result side stalls at random; the percentage is set per phase.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Works out the answer to one status request and moves the predictor
    // state on exactly as the block is meant to.
    function automatic lfom_pkg::lfom_out_t predict_report(lfom_pkg::lfom_in_t req);
        lfom_pkg::lfom_out_t          res;
        int unsigned                  slot;
        bit                           hit;
        logic [TB_W-1:0]              win_ms;
        logic [TB_W-1:0]              tmo_ms;
        logic [TB_W-1:0]              elapsed;
        logic [lfom_pkg::COUNT_W-1:0] lim;
        res = '0;
        slot = 0;
        hit = 1'b0;
        // An empty address is refused without touching any state.
        if (req.device_address == '0) begin
            res.dropped = 1'b1;
            return res;
        end
        for (int i = 0; i < dev_count; i++) begin
            if (dev_table[i] == req.device_address) begin
                slot = i;
                hit = 1'b1;
            end
        end
        if (!hit) begin
            // A new device with no room left is refused like an empty one.
            if (dev_count >= DEPTH) begin
                res.dropped = 1'b1;
                return res;
            end
            slot = dev_count;
            dev_table[slot] = req.device_address;
            chg_cnt[slot] = '0;
            win_on[slot] = 1'b0;
            was_down[slot] = 1'b1;
            down_timing[slot] = 1'b0;
            dev_count++;
            res.new_entry = 1'b1;
        end
        // A zero window or zero limit falls back to the default pair.
        if (cur_window == '0 || cur_limit == '0) begin
            win_ms = TB_W'(lfom_pkg::DEF_WINDOW_MIN * lfom_pkg::MS_PER_MINUTE);
            lim = lfom_pkg::COUNT_W'(lfom_pkg::DEF_LIMIT);
        end else begin
            win_ms = cur_window * TB_W'(lfom_pkg::MS_PER_MINUTE);
            lim = lfom_pkg::COUNT_W'(cur_limit);
        end
        if (!win_on[slot]) begin
            win_start[slot] = req.now_ms;
            win_on[slot] = 1'b1;
        end
        elapsed = req.now_ms - win_start[slot];
        if (was_down[slot] != req.is_disconnected) begin
            // A change at exactly the window length still counts inside it.
            if (elapsed <= win_ms) begin
                chg_cnt[slot] = chg_cnt[slot] + 1'b1;
            end else begin
                chg_cnt[slot] = '0;
                win_start[slot] = req.now_ms;
            end
            was_down[slot] = req.is_disconnected;
        end else if (elapsed > win_ms) begin
            chg_cnt[slot] = '0;
            win_start[slot] = req.now_ms;
        end
        if (chg_cnt[slot] > lim) begin
            res.flap_alarm = 1'b1;
            chg_cnt[slot] = '0;
        end
        if (cur_outage == '0) begin
            tmo_ms = TB_W'(lfom_pkg::DEF_OUTAGE_MIN * lfom_pkg::MS_PER_MINUTE);
        end else begin
            tmo_ms = cur_outage * TB_W'(lfom_pkg::MS_PER_MINUTE);
        end
        if (req.is_disconnected) begin
            if (!down_timing[slot]) begin
                down_start[slot] = req.now_ms;
                down_timing[slot] = 1'b1;
            end else if (TB_W'(req.now_ms - down_start[slot]) > tmo_ms) begin
                down_timing[slot] = 1'b0;
                res.outage_alarm = 1'b1;
            end
        end else begin
            // A connected report restarts the disconnect timer.
            down_start[slot] = req.now_ms;
            down_timing[slot] = 1'b1;
        end
        res.entry_slot = slot[lfom_pkg::SLOT_W-1:0];
        return res;
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        $display("%0t ns: mismatch in %s: expected %0h, got %0h", $time, what, want, got);
        mismatch_count++;
    endtask

    // Each accepted result is compared with the oldest outstanding prediction.
    always @(posedge aclk) begin
        lfom_pkg::lfom_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing outstanding", '0, 64'(m_data));
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (want.entry_slot !== m_data.entry_slot)
                    report_mismatch("entry_slot", 64'(want.entry_slot),
                                    64'(m_data.entry_slot));
                if (want.new_entry !== m_data.new_entry)
                    report_mismatch("new_entry", 64'(want.new_entry), 64'(m_data.new_entry));
                if (want.dropped !== m_data.dropped)
                    report_mismatch("dropped", 64'(want.dropped), 64'(m_data.dropped));
                if (want.flap_alarm !== m_data.flap_alarm)
                    report_mismatch("flap_alarm", 64'(want.flap_alarm),
                                    64'(m_data.flap_alarm));
                if (want.outage_alarm !== m_data.outage_alarm)
                    report_mismatch("outage_alarm", 64'(want.outage_alarm),
                                    64'(m_data.outage_alarm));
            end
        end
    end

    // The watchdog restarts on any handshake or register write. If the block
    // hangs, nothing moves and the run is ended here.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("[link_flap_and_outage_monitor_unit] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one status request and returns at the edge where it is taken.
    // Valid is lowered only when the sender decides to idle, so back-to-back
    // requests keep it high without a second assignment in the same step.
    task automatic send_report(logic [lfom_pkg::ADDR_W-1:0] addr, bit down,
                               logic [TB_W-1:0] now);
        lfom_pkg::lfom_in_t req;
        req.device_address = addr;
        req.is_disconnected = down;
        req.now_ms = now;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_report(req));
    endtask

    // Holds the sender off until the block has answered everything.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Register writes happen only with the block idle; the predictor copy is
    // updated at the same time. Undecoded indexes leave everything alone.
    task automatic write_register(logic [lfom_pkg::CFG_IDX_W-1:0] idx,
                                  logic [lfom_pkg::CFG_DATA_W-1:0] val);
        unique case (idx)
            lfom_pkg::CFG_WINDOW_MINUTES: cur_window = val;
            lfom_pkg::CFG_MAX_CHANGES:    cur_limit = val[lfom_pkg::LIMIT_W-1:0];
            lfom_pkg::CFG_OUTAGE_MINUTES: cur_outage = val;
            default: ;
        endcase
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Empty addresses are refused, at both ends of the timestamp range.
    task automatic test_empty_address();
        send_report('0, 1'b1, '0);
        send_report('0, 1'b0, '1);
    endtask

    // With the reset limit of five, the sixth change inside the window raises
    // the flap alarm. The timestamps stay just short of the wrap of the time counter.
    task automatic test_flap_alarm();
        send_report(pool_addr[0], 1'b1, clock_ms);
        for (int k = 1; k <= 6; k++) begin
            clock_ms = clock_ms + 10000;
            send_report(pool_addr[0], k[0] ? 1'b0 : 1'b1, clock_ms);
        end
    endtask

    // A change at exactly the window length counts; one past a further
    // window restarts the count.
    task automatic test_window_boundary();
        logic [TB_W-1:0] t0;
        t0 = clock_ms;
        send_report(pool_addr[1], 1'b1, t0);
        send_report(pool_addr[1], 1'b0,
                    t0 + lfom_pkg::RST_WINDOW_MIN * lfom_pkg::MS_PER_MINUTE);
        send_report(pool_addr[1], 1'b1,
                    t0 + 2 * lfom_pkg::RST_WINDOW_MIN * lfom_pkg::MS_PER_MINUTE + 1);
        clock_ms = t0 + 2 * lfom_pkg::RST_WINDOW_MIN * lfom_pkg::MS_PER_MINUTE + 1;
    endtask

    // With the reset timeout of one minute, a disconnect of exactly one
    // minute is quiet, one millisecond more raises the alarm, the next
    // disconnected report starts timing again and a connected one restarts it.
    task automatic test_outage_alarm();
        logic [TB_W-1:0] t0;
        t0 = clock_ms;
        send_report(pool_addr[2], 1'b1, t0);
        send_report(pool_addr[2], 1'b1, t0 + lfom_pkg::MS_PER_MINUTE);
        send_report(pool_addr[2], 1'b1, t0 + lfom_pkg::MS_PER_MINUTE + 1);
        send_report(pool_addr[2], 1'b1, t0 + lfom_pkg::MS_PER_MINUTE + 2);
        send_report(pool_addr[2], 1'b0, t0 + lfom_pkg::MS_PER_MINUTE + 10000);
        clock_ms = t0 + lfom_pkg::MS_PER_MINUTE + 10000;
    endtask

    // Zero in every register selects the defaults; a write to the undecoded
    // index must change nothing. The default timeout is five minutes.
    task automatic test_zero_registers();
        logic [TB_W-1:0] t0;
        wait_drained();
        write_register(lfom_pkg::CFG_WINDOW_MINUTES, '0);
        write_register(lfom_pkg::CFG_MAX_CHANGES, '0);
        write_register(lfom_pkg::CFG_OUTAGE_MINUTES, '0);
        write_register(CFG_UNUSED_INDEX, '1);
        t0 = clock_ms;
        send_report(pool_addr[3], 1'b1, t0);
        send_report(pool_addr[3], 1'b1,
                    t0 + lfom_pkg::DEF_OUTAGE_MIN * lfom_pkg::MS_PER_MINUTE);
        send_report(pool_addr[3], 1'b1,
                    t0 + lfom_pkg::DEF_OUTAGE_MIN * lfom_pkg::MS_PER_MINUTE + 1);
        clock_ms = t0 + lfom_pkg::DEF_OUTAGE_MIN * lfom_pkg::MS_PER_MINUTE + 1;
    endtask

    // Random traffic over several register settings, extremes among them.
    // The remaining table slots are filled first, after which unknown
    // devices are refused. Most requests come from the known devices, often
    // in bursts from one device with toggling status so that flap windows
    // and outage timers are really exercised.
    task automatic test_random_traffic();
        int unsigned ph_win [PHASE_COUNT] = '{1, 1440, 2047, 3, 0, 10};
        int unsigned ph_lim [PHASE_COUNT] = '{1, 255, 2047, 2, 4, 1};
        int unsigned ph_out [PHASE_COUNT] = '{1, 1440, 2047, 2, 7, 0};
        int unsigned eff_win;
        int unsigned eff_tmo;
        int unsigned pick;
        int unsigned r;
        logic [lfom_pkg::ADDR_W-1:0] addr;
        bit down;
        for (int i = 0; i < DEPTH; i++) begin
            send_report(pool_addr[i], 1'($urandom_range(1)), clock_ms);
            clock_ms = clock_ms + $urandom_range(5000);
        end
        pick = 0;
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            // The sender always waits for the block to empty before a change
            // of settings.
            wait_drained();
            unique case (ph / 2)
                0: begin send_idle_pct = 31; recv_idle_pct = 87; end
                1: begin send_idle_pct = 87; recv_idle_pct = 31; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            write_register(lfom_pkg::CFG_WINDOW_MINUTES, lfom_pkg::CFG_DATA_W'(ph_win[ph]));
            write_register(lfom_pkg::CFG_MAX_CHANGES, lfom_pkg::CFG_DATA_W'(ph_lim[ph]));
            write_register(lfom_pkg::CFG_OUTAGE_MINUTES, lfom_pkg::CFG_DATA_W'(ph_out[ph]));
            eff_win = (cur_window == 0 || cur_limit == 0) ?
                      lfom_pkg::DEF_WINDOW_MIN * lfom_pkg::MS_PER_MINUTE :
                      cur_window * lfom_pkg::MS_PER_MINUTE;
            eff_tmo = (cur_outage == 0) ? lfom_pkg::DEF_OUTAGE_MIN * lfom_pkg::MS_PER_MINUTE
                                        : cur_outage * lfom_pkg::MS_PER_MINUTE;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                r = $urandom_range(99);
                if (r < 4) begin
                    addr = '0;
                    down = 1'($urandom_range(1));
                end else if (r < 9) begin
                    addr = $urandom;
                    down = 1'($urandom_range(1));
                end else begin
                    if ($urandom_range(1) == 0)
                        pick = $urandom_range(DEPTH - 1);
                    addr = pool_addr[pick];
                    down = ($urandom_range(9) < 6) ? !pool_disc[pick]
                                                   : 1'($urandom_range(1));
                    pool_disc[pick] = down;
                end
                // Short steps for bursts most often, some at the scale of the window
                // or the timeout, some with no step at all, and the odd jump anywhere in time.
                r = $urandom_range(19);
                if (r < 8)
                    clock_ms = clock_ms + $urandom_range(2000);
                else if (r < 12)
                    clock_ms = clock_ms + $urandom_range(eff_win / 8);
                else if (r < 17)
                    clock_ms = clock_ms + $urandom_range(eff_tmo / 4);
                else if (r == 19)
                    clock_ms = {16'($urandom), 32'($urandom)};
                send_report(addr, down, clock_ms);
            end
        end
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            dev_table[i] = '0;
            chg_cnt[i] = '0;
            win_start[i] = '0;
            win_on[i] = 1'b0;
            was_down[i] = 1'b1;
            down_start[i] = '0;
            down_timing[i] = 1'b0;
            pool_disc[i] = 1'b1;
            pool_addr[i] = $urandom | 32'h1;
        end
        dev_count = 0;
        // Devices with the extreme addresses are among the known ones.
        pool_addr[0] = 32'hFFFF_FFFF;
        pool_addr[1] = 32'h0000_0001;
        pool_addr[2] = 32'h5555_AAAA;
        pool_addr[3] = 32'hAAAA_5555;
        // Start just short of the wrap so that early differences cross it.
        clock_ms = 48'hFFFF_FFFF_0000;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_address();
        test_flap_alarm();
        test_window_boundary();
        test_outage_alarm();
        test_zero_registers();
        test_random_traffic();

        wait_drained();
        repeat (RESULT_LATENCY) @(posedge aclk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", '0, 64'(pending_results.size()));
        if (mismatch_count == 0) begin
            $display("[link_flap_and_outage_monitor_unit] OK");
        end else begin
            $display("[link_flap_and_outage_monitor_unit] ERROR");
        end
        $finish;
    end

endmodule

// File: link_flap_and_outage_monitor_unit.f
+incdir+src
src/lfom_pkg.sv
src/link_flap_and_outage_monitor_unit.sv
tb/tb_link_flap_and_outage_monitor_unit.sv
